### rtl/edu_pkg.sv
// edu_pkg: shared types, codes and helpers for the edit distance unit.
// No dependencies; every other file uses it.
package edu_pkg;

    localparam int COST_W = 6;
    localparam int SYM_W  = 8;

    typedef logic [COST_W-1:0] t_cost;
    typedef logic [SYM_W-1:0]  t_sym;

    typedef enum logic [1:0] {
        KIND_REF = 2'd0,
        KIND_CMP = 2'd1,
        KIND_END = 2'd2
    } t_kind;

    // Wave token handed from cell to cell: one row update in flight.
    typedef struct packed {
        logic  valid;
        t_cost diag;
        t_cost left;
        t_sym  sym;
    } t_wave;

    // Per-cell control from the top level.
    typedef struct packed {
        logic init;
        logic clear;
        logic wr;
        t_sym sym;
    } t_cell_ctl;

    function automatic t_cost min3(input logic [COST_W:0] p, input logic [COST_W:0] q,
                                   input logic [COST_W:0] r);
        logic [COST_W:0] m;
        m = p;
        if (q < m) begin
            m = q;
        end
        if (r < m) begin
            m = r;
        end
        return m[COST_W-1:0];
    endfunction

endpackage

### rtl/edu_in_if.sv
// edu_in_if: input channel of the edit distance unit (kind, symbol).
// Depends on edu_pkg for the field widths.
interface edu_in_if;
    logic                 valid;
    logic                 ready;
    logic [1:0]           kind;
    logic [edu_pkg::SYM_W-1:0] symbol;

    modport source (output valid, output kind, output symbol, input ready);
    modport sink   (input valid, input kind, input symbol, output ready);
endinterface

### rtl/edu_out_if.sv
// edu_out_if: result channel of the edit distance unit (distance, error).
// Depends on edu_pkg for the field widths.
interface edu_out_if;
    logic                       valid;
    logic                       ready;
    logic [edu_pkg::COST_W-1:0] distance;
    logic                       error;

    modport source (output valid, output distance, output error, input ready);
    modport sink   (input valid, input distance, input error, output ready);
endinterface

### rtl/edit_distance_unit.sv
// edit_distance_unit: Levenshtein distance over a chain of column cells.
// Depends on edu_pkg, edu_in_if, edu_out_if and edu_cell.
//
//   channel  | dir | payload          | beat meaning
//   ---------+-----+------------------+-------------------------------------
//   i_in     | in  | kind, symbol     | reference char, compared char or end
//   o_out    | out | distance, error  | one result per end beat
//
// A compared-string beat launches a wave token that walks the cell chain
// one cell per cycle, and the next beat is not taken until the token has
// passed the last reference column. Synchronous active-low reset clears
// the counters and the cell valid bits. The result sits in an output
// register; input is also held off while that register is full and not
// being taken.
module edit_distance_unit #(
    parameter int MAX_LEN = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    edu_in_if.sink    i_in,
    edu_out_if.source o_out
);
    import edu_pkg::*;

    localparam int CW = $clog2(MAX_LEN + 1);

    logic [CW-1:0] r_ref_len;
    logic [CW-1:0] r_cmp_cnt;
    logic [CW-1:0] r_wave_cnt;
    logic          r_started;
    logic          r_err;
    t_wave         r_tok;
    logic          r_out_valid;
    t_cost         r_out_dist;
    logic          r_out_err;

    logic          accept;
    logic          take_ref;
    logic          take_cmp;
    logic          take_end;
    logic          drop;
    t_cost         n_dist;
    t_wave         w_wave [0:MAX_LEN];
    t_cost         w_cost [0:MAX_LEN-1];

    assign i_in.ready = (r_wave_cnt == '0) && (!r_out_valid || o_out.ready);
    assign accept     = i_in.valid && i_in.ready;

    // Decode the beat; drop late or overflowing characters and flag them.
    always_comb begin
        take_ref = 1'b0;
        take_cmp = 1'b0;
        take_end = 1'b0;
        drop     = 1'b0;
        if (accept) begin
            case (t_kind'(i_in.kind))
                KIND_REF: begin
                    if (r_started || r_ref_len >= CW'(MAX_LEN)) begin
                        drop = 1'b1;
                    end else begin
                        take_ref = 1'b1;
                    end
                end
                KIND_CMP: begin
                    if (r_cmp_cnt >= CW'(MAX_LEN)) begin
                        drop = 1'b1;
                    end else begin
                        take_cmp = 1'b1;
                    end
                end
                KIND_END: begin
                    take_end = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // Pick the distance: last active column, or a length for an empty string.
    always_comb begin
        n_dist = t_cost'(r_ref_len);
        if (r_cmp_cnt == '0) begin
            n_dist = t_cost'(r_ref_len);
        end else if (r_ref_len == '0) begin
            n_dist = t_cost'(r_cmp_cnt);
        end else begin
            for (int j = 0; j < MAX_LEN; j++) begin
                if (r_ref_len == CW'(j + 1)) begin
                    n_dist = w_cost[j];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_len   <= '0;
            r_cmp_cnt   <= '0;
            r_wave_cnt  <= '0;
            r_started   <= 1'b0;
            r_err       <= 1'b0;
            r_tok.valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_tok.valid <= take_cmp;
            if (take_cmp) begin
                // Hold off new beats until the token passes the last column.
                r_wave_cnt <= r_ref_len;
                r_cmp_cnt  <= r_cmp_cnt + CW'(1);
                r_started  <= 1'b1;
            end else if (r_wave_cnt != '0) begin
                r_wave_cnt <= r_wave_cnt - CW'(1);
            end
            if (take_ref) begin
                r_ref_len <= r_ref_len + CW'(1);
            end
            if (drop) begin
                r_err <= 1'b1;
            end
            if (take_end) begin
                r_out_valid <= 1'b1;
                r_ref_len   <= '0;
                r_cmp_cnt   <= '0;
                r_started   <= 1'b0;
                r_err       <= 1'b0;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (take_cmp) begin
            r_tok.diag <= t_cost'(r_cmp_cnt);
            r_tok.left <= t_cost'(r_cmp_cnt) + t_cost'(1);
            r_tok.sym  <= i_in.symbol;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_end) begin
            r_out_dist <= n_dist;
            r_out_err  <= r_err || drop;
        end
    end

    assign w_wave[0] = r_tok;

    for (genvar j = 0; j < MAX_LEN; j++) begin : g_cell
        t_cell_ctl ctl;

        always_comb begin
            ctl.init  = take_cmp && !r_started;
            ctl.clear = take_end;
            ctl.wr    = take_ref && (r_ref_len == CW'(j));
            ctl.sym   = i_in.symbol;
        end

        edu_cell #(
            .IDX (j)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_wave  (w_wave[j]),
            .o_wave  (w_wave[j+1]),
            .o_cost  (w_cost[j])
        );
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.distance = r_out_dist;
    assign o_out.error    = r_out_err;

endmodule

### rtl/edu_cell.sv
// edu_cell: one column of the edit distance row: reference char and cost.
// Depends on edu_pkg (t_wave, t_cell_ctl, min3).
module edu_cell #(
    parameter int IDX = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  edu_pkg::t_cell_ctl i_ctl,
    input  edu_pkg::t_wave     i_wave,
    output edu_pkg::t_wave     o_wave,
    output edu_pkg::t_cost     o_cost
);
    import edu_pkg::*;

    logic  r_used;
    t_sym  r_ref;
    t_cost r_cost;
    t_wave r_wave;
    t_cost n_val;

    always_comb begin
        n_val = min3({1'b0, r_cost} + 7'd1,
                     {1'b0, i_wave.left} + 7'd1,
                     {1'b0, i_wave.diag} + {6'd0, (r_ref != i_wave.sym)});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used       <= 1'b0;
            r_wave.valid <= 1'b0;
        end else begin
            if (i_ctl.clear) begin
                r_used <= 1'b0;
            end else if (i_ctl.wr) begin
                r_used <= 1'b1;
            end
            r_wave.valid <= i_wave.valid;
        end
        // Old cost becomes the next cell's diagonal; new cost its left.
        r_wave.diag <= r_cost;
        r_wave.left <= n_val;
        r_wave.sym  <= i_wave.sym;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_ref <= i_ctl.sym;
        end
        if (i_ctl.init) begin
            r_cost <= t_cost'(IDX + 1);
        end else if (i_wave.valid && r_used) begin
            r_cost <= n_val;
        end
    end

    assign o_wave = r_wave;
    assign o_cost = r_cost;

endmodule

### test/tb_edit_distance_unit.sv
// tb_edit_distance_unit: self-checking bench for the edit distance unit.
// Depends on edu_pkg, edu_in_if, edu_out_if and the edit_distance_unit RTL.
// Streams string pairs under varied idling and checks every result against a
// local dynamic-programming predictor.
module tb_edit_distance_unit;
    import edu_pkg::*;

    localparam int MAX_LEN       = 32;
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int PHASE_ITEMS   = 100;
    localparam int HOLD_AT_BEAT  = 50;
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 4000;
    localparam int DRAIN_CYCLES  = 2 * MAX_LEN + 8;

    typedef struct {
        logic [1:0] kind;
        t_sym       symbol;
        int         phase;
    } t_beat;

    typedef struct {
        int distance;
        bit error;
    } t_dist_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    edu_in_if  in_ch ();
    edu_out_if out_ch ();

    edit_distance_unit #(
        .MAX_LEN (MAX_LEN)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    t_beat        stim_q[$];
    t_dist_result distance_q[$];

    // Predictor state for the pair in progress.
    t_sym ref_syms[MAX_LEN];
    int   row_cost[MAX_LEN];
    int   ref_len     = 0;
    int   cmp_count   = 0;
    bit   cmp_started = 1'b0;
    bit   dropped     = 1'b0;

    int   mismatches   = 0;
    int   results_seen = 0;
    int   error_results = 0;
    int   max_distance = 0;
    int   beats_sent   = 0;
    int   cur_phase    = 0;
    int   hold_left    = 0;
    bit   hold_done    = 1'b0;
    bit   in_beat_taken = 1'b0;
    int   quiet_cycles = 0;

    // Idle odds per phase: free-running, sender idle, receiver stall, both light.
    function automatic int send_idle_pct(input int phase);
        case (phase)
            1: return 81;
            3: return 11;
            default: return 0;
        endcase
    endfunction

    function automatic int recv_stall_pct(input int phase);
        case (phase)
            2: return 81;
            3: return 11;
            default: return 0;
        endcase
    endfunction

    function automatic bit idle_roll(input int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic void queue_beat(input logic [1:0] kind, input int sym, input int phase);
        t_beat b;
        b.kind   = kind;
        b.symbol = t_sym'(sym);
        b.phase  = phase;
        stim_q.push_back(b);
    endfunction

    // Mostly short strings; now and then a full or overflowing one.
    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            return 0;
        end else if (r < 88) begin
            return $urandom_range(1, 8);
        end else if (r < 94) begin
            return $urandom_range(9, MAX_LEN - 1);
        end
        return $urandom_range(MAX_LEN, MAX_LEN + 2);
    endfunction

    // Queue one pair with random content; returns the number of beats queued, not counting an unused-kind beat.
    function automatic int queue_pair(input int phase);
        int  r_len;
        int  c_len;
        bit  narrow;
        int  n;
        int  k;
        n      = 0;
        r_len  = pick_len();
        c_len  = pick_len();
        narrow = $urandom_range(0, 2) != 0;
        for (k = 0; k < r_len; k++) begin
            queue_beat(KIND_REF, narrow ? 'h61 + $urandom_range(0, 3) : $urandom_range(0, 255),
                       phase);
            n++;
        end
        if ($urandom_range(0, 9) == 0) begin
            queue_beat(KIND_UNUSED, $urandom_range(0, 255), phase);
        end
        for (k = 0; k < c_len; k++) begin
            queue_beat(KIND_CMP, narrow ? 'h61 + $urandom_range(0, 3) : $urandom_range(0, 255),
                       phase);
            n++;
            // occasionally slip a reference char into the compared string
            if ($urandom_range(0, 39) == 0) begin
                queue_beat(KIND_REF, $urandom_range(0, 255), phase);
                n++;
            end
        end
        // now and then leave the pair open so the next one runs into it
        if ($urandom_range(0, 14) != 0) begin
            queue_beat(KIND_END, $urandom_range(0, 255), phase);
            n++;
        end
        return n;
    endfunction

    // Advance the predictor by one accepted beat; queue a result on an end beat.
    task automatic step_distance(input logic [1:0] kind, input t_sym sym);
        int diag;
        int left;
        int up;
        int sub;
        int best;
        int j;
        t_dist_result res;
        case (kind)
            KIND_REF: begin
                if (cmp_started || ref_len >= MAX_LEN) begin
                    dropped = 1'b1;
                end else begin
                    ref_syms[ref_len] = sym;
                    ref_len++;
                end
            end
            KIND_CMP: begin
                if (cmp_count >= MAX_LEN) begin
                    dropped = 1'b1;
                end else begin
                    if (!cmp_started) begin
                        for (j = 0; j < ref_len; j++) begin
                            row_cost[j] = j + 1;
                        end
                        cmp_started = 1'b1;
                    end
                    diag = cmp_count;
                    left = cmp_count + 1;
                    for (j = 0; j < ref_len; j++) begin
                        up   = row_cost[j];
                        sub  = diag + ((ref_syms[j] == sym) ? 0 : 1);
                        best = up + 1;
                        if (left + 1 < best) begin
                            best = left + 1;
                        end
                        if (sub < best) begin
                            best = sub;
                        end
                        diag        = up;
                        row_cost[j] = best;
                        left        = best;
                    end
                    cmp_count++;
                end
            end
            KIND_END: begin
                if (cmp_count == 0) begin
                    res.distance = ref_len;
                end else if (ref_len == 0) begin
                    res.distance = cmp_count;
                end else begin
                    res.distance = row_cost[ref_len - 1];
                end
                res.error = dropped;
                distance_q.push_back(res);
                ref_len     = 0;
                cmp_count   = 0;
                cmp_started = 1'b0;
                dropped     = 1'b0;
            end
            default: begin
                // unused kind: nothing changes
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("mismatch: %s: got %0d, want %0d", what, got, want);
    endtask

    // Sender: present the next queued beat once the previous one is taken.
    always @(negedge i_clk) begin : drive_in
        t_beat b;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_beat_taken) begin
            if (stim_q.size() != 0 && !idle_roll(send_idle_pct(stim_q[0].phase))) begin
                b = stim_q.pop_front();
                in_ch.valid  <= 1'b1;
                in_ch.kind   <= b.kind;
                in_ch.symbol <= b.symbol;
                cur_phase    <= b.phase;
                beats_sent   <= beats_sent + 1;
            end else begin
                in_ch.valid  <= 1'b0;
                in_ch.kind   <= 2'($urandom_range(0, 3));
                in_ch.symbol <= t_sym'($urandom_range(0, 255));
            end
        end
    end

    // Long receiver hold-off, once, while the sender keeps offering beats.
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && beats_sent >= HOLD_AT_BEAT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    always @(negedge i_clk) begin
        out_ch.ready <= i_rst_n && hold_left == 0 && !idle_roll(recv_stall_pct(cur_phase));
    end

    // Monitor: check results first, then fold the accepted input beat in.
    always @(posedge i_clk) begin : watch_beats
        t_dist_result want;
        in_beat_taken <= i_rst_n && in_ch.valid && in_ch.ready;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                results_seen++;
                if (distance_q.size() == 0) begin
                    report_mismatch("result with nothing pending, distance",
                                    int'(out_ch.distance), -1);
                end else begin
                    want = distance_q.pop_front();
                    if (out_ch.distance !== t_cost'(want.distance)) begin
                        report_mismatch("distance", int'(out_ch.distance), want.distance);
                    end
                    if (out_ch.error !== want.error) begin
                        report_mismatch("error flag", int'(out_ch.error), int'(want.error));
                    end
                    if (want.error) begin
                        error_results++;
                    end
                    if (want.distance > max_distance) begin
                        max_distance = want.distance;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                step_distance(in_ch.kind, in_ch.symbol);
            end
        end
    end

    // Watchdog: too long without any beat on either side ends the run.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
                $display("timeout: no beat accepted for %0d cycles", STALL_LIMIT);
                $display("== FAIL ==");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        int p;
        int n;
        in_ch.valid  = 1'b0;
        in_ch.kind   = KIND_REF;
        in_ch.symbol = '0;
        out_ch.ready = 1'b0;

        // Directed pairs: empty pair, empty compared, empty reference,
        // extreme bytes, an unused kind, a late reference char.
        queue_beat(KIND_END, 'h00, 0);
        queue_beat(KIND_REF, 'h00, 0);
        queue_beat(KIND_REF, 'hFF, 0);
        queue_beat(KIND_END, 'hFF, 0);
        queue_beat(KIND_CMP, 'hFF, 0);
        queue_beat(KIND_CMP, 'h00, 0);
        queue_beat(KIND_CMP, 'h55, 0);
        queue_beat(KIND_END, 'h00, 0);
        queue_beat(KIND_REF, 'h00, 0);
        queue_beat(KIND_REF, 'hFF, 0);
        queue_beat(KIND_CMP, 'hFF, 0);
        queue_beat(KIND_UNUSED, 'hAA, 0);
        queue_beat(KIND_CMP, 'h00, 0);
        queue_beat(KIND_END, 'h55, 0);
        queue_beat(KIND_REF, 'h41, 0);
        queue_beat(KIND_REF, 'h42, 0);
        queue_beat(KIND_REF, 'h43, 0);
        queue_beat(KIND_CMP, 'h41, 0);
        queue_beat(KIND_CMP, 'h43, 0);
        queue_beat(KIND_REF, 'h44, 0);
        queue_beat(KIND_END, 'h00, 0);
        queue_beat(KIND_REF, 'h7F, 0);
        queue_beat(KIND_CMP, 'h80, 0);
        queue_beat(KIND_END, 'hFF, 0);

        // Random pairs, one block of them per idling phase.
        for (p = 0; p < 4; p++) begin
            n = 0;
            while (n < PHASE_ITEMS) begin
                n += queue_pair(p);
            end
        end
        queue_beat(KIND_END, 'h00, 3);

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (stim_q.size() != 0 || in_ch.valid) begin
            @(posedge i_clk);
        end
        while (distance_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d input beats and %0d results, %0d of them flagged as errors",
                 beats_sent, results_seen, error_results);
        $display("largest distance seen %0d; receiver held off once for %0d cycles",
                 max_distance, HOLD_CYCLES);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
